FILE: sv/framed_command_parser_defines.svh
// Assertion macros used by the port checker (fcp_checker) of the command parser.
// Needs a clk and an rst_n in scope at the point of use.
`ifndef FRAMED_COMMAND_PARSER_DEFINES_SVH
`define FRAMED_COMMAND_PARSER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define FCP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framed_command_parser: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define FCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framed_command_parser: next-cycle check failed");

`endif

FILE: sv/fcp_pkg.sv
// Types, constants and codes of the framed command parser.
// No dependencies; used by every module of the block.
package fcp_pkg;

  localparam int BUFFER_DEPTH = 16;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);

  localparam logic [7:0] SYM_START = 8'h23;
  localparam logic [7:0] SYM_END   = 8'h21;
  localparam logic [7:0] CMD_P     = 8'h50;
  localparam logic [7:0] CMD_S     = 8'h53;

  localparam logic [1:0] MODE_APPEND   = 2'd0;
  localparam logic [1:0] MODE_DECODE   = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_INCOMPLETE = 3'd1;
  localparam logic [2:0] ST_INVALID    = 3'd2;
  localparam logic [2:0] ST_CHECKSUM   = 3'd3;
  localparam logic [2:0] ST_FRAMING    = 3'd4;
  localparam logic [2:0] ST_NOSTART    = 3'd5;
  localparam logic [2:0] ST_FULL       = 3'd6;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] gain_p;
    logic [7:0] gain_i;
    logic [7:0] gain_d;
    logic       report_request;
  } out_item_t;

  typedef enum logic [0:0] {
    CS_IDLE,
    CS_SCAN
  } ctl_state_t;

  typedef enum logic [3:0] {
    PH_SEEK,
    PH_CMD,
    PH_KP,
    PH_TI,
    PH_TD,
    PH_CS,
    PH_PEND,
    PH_SEND,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic start;
    logic step;
    logic empty;
  } scan_ctl_t;

  typedef struct packed {
    logic [2:0] status;
    logic       load;
    logic       report;
    logic [7:0] kp;
    logic [7:0] ti;
    logic [7:0] td;
  } scan_res_t;

endpackage

FILE: sv/fcp_cell.sv
// One byte cell of the buffer ring: loads on append, takes its neighbor's byte on rotate.
// Depends on fcp_pkg.
module fcp_cell (
  input  logic                 clk,
  input  fcp_pkg::cell_ctl_t   ctl,
  input  logic [7:0]           load_byte,
  input  logic [7:0]           shift_in,
  output logic [7:0]           byte_q
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.load) begin
      byte_nxt = load_byte;
    end else if (ctl.shift) begin
      byte_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q = byte_r;

endmodule

FILE: sv/fcp_scanner.sv
// Frame parser fed one buffer byte per cycle from the head of the cell ring.
// Depends on fcp_pkg.
module fcp_scanner (
  input  logic                clk,
  input  logic                rst_n,
  input  fcp_pkg::scan_ctl_t  ctl,
  input  logic [7:0]          head_byte,
  input  logic                in_range,
  output fcp_pkg::scan_res_t  res
);

  fcp_pkg::phase_t phase_r, phase_nxt;
  logic [2:0] status_r, status_nxt;
  logic       load_r, load_nxt;
  logic       report_r, report_nxt;
  logic [7:0] kp_r, kp_nxt;
  logic [7:0] ti_r, ti_nxt;
  logic [7:0] td_r, td_nxt;
  logic [7:0] cs_r, cs_nxt;
  logic [7:0] sum_r, sum_nxt;

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    status_nxt = status_r;
    load_nxt   = load_r;
    report_nxt = report_r;
    kp_nxt     = kp_r;
    ti_nxt     = ti_r;
    td_nxt     = td_r;
    cs_nxt     = cs_r;
    sum_nxt    = sum_r;
    if (ctl.start) begin
      phase_nxt  = fcp_pkg::PH_SEEK;
      status_nxt = fcp_pkg::ST_INCOMPLETE;
      load_nxt   = 1'b0;
      report_nxt = 1'b0;
    end else if (ctl.step) begin
      case (phase_r)
        fcp_pkg::PH_SEEK: begin
          if (in_range && head_byte == fcp_pkg::SYM_START) begin
            phase_nxt = fcp_pkg::PH_CMD;
          end
        end
        fcp_pkg::PH_CMD: begin
          if (!in_range) begin
            phase_nxt  = fcp_pkg::PH_DONE;
            status_nxt = fcp_pkg::ST_INCOMPLETE;
          end else if (head_byte == fcp_pkg::CMD_P) begin
            phase_nxt = fcp_pkg::PH_KP;
          end else if (head_byte == fcp_pkg::CMD_S) begin
            phase_nxt = fcp_pkg::PH_SEND;
          end else begin
            phase_nxt  = fcp_pkg::PH_DONE;
            status_nxt = fcp_pkg::ST_INVALID;
          end
        end
        fcp_pkg::PH_KP, fcp_pkg::PH_TI, fcp_pkg::PH_TD, fcp_pkg::PH_CS: begin
          if (!in_range) begin
            phase_nxt  = fcp_pkg::PH_DONE;
            status_nxt = fcp_pkg::ST_INCOMPLETE;
          end else begin
            case (phase_r)
              fcp_pkg::PH_KP: begin
                kp_nxt    = head_byte;
                sum_nxt   = fcp_pkg::CMD_P + head_byte;
                phase_nxt = fcp_pkg::PH_TI;
              end
              fcp_pkg::PH_TI: begin
                ti_nxt    = head_byte;
                sum_nxt   = sum_r + head_byte;
                phase_nxt = fcp_pkg::PH_TD;
              end
              fcp_pkg::PH_TD: begin
                td_nxt    = head_byte;
                sum_nxt   = sum_r + head_byte;
                phase_nxt = fcp_pkg::PH_CS;
              end
              default: begin
                cs_nxt    = head_byte;
                phase_nxt = fcp_pkg::PH_PEND;
              end
            endcase
          end
        end
        fcp_pkg::PH_PEND: begin
          phase_nxt = fcp_pkg::PH_DONE;
          if (!in_range) begin
            status_nxt = fcp_pkg::ST_INCOMPLETE;
          end else if (head_byte != fcp_pkg::SYM_END) begin
            status_nxt = fcp_pkg::ST_FRAMING;
          end else if (sum_r != cs_r) begin
            status_nxt = fcp_pkg::ST_CHECKSUM;
          end else begin
            status_nxt = fcp_pkg::ST_OK;
            load_nxt   = 1'b1;
          end
        end
        fcp_pkg::PH_SEND: begin
          phase_nxt = fcp_pkg::PH_DONE;
          if (!in_range) begin
            status_nxt = fcp_pkg::ST_INCOMPLETE;
          end else if (head_byte != fcp_pkg::SYM_END) begin
            status_nxt = fcp_pkg::ST_FRAMING;
          end else begin
            status_nxt = fcp_pkg::ST_OK;
            report_nxt = 1'b1;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // outputs: verdict as of the final byte; frames still open at ring end are cut short
  always_comb begin
    res.kp     = kp_nxt;
    res.ti     = ti_nxt;
    res.td     = td_nxt;
    res.load   = 1'b0;
    res.report = 1'b0;
    if (ctl.empty) begin
      res.status = fcp_pkg::ST_INCOMPLETE;
    end else if (phase_nxt == fcp_pkg::PH_DONE) begin
      res.status = status_nxt;
      res.load   = load_nxt;
      res.report = report_nxt;
    end else if (phase_nxt == fcp_pkg::PH_SEEK) begin
      res.status = fcp_pkg::ST_NOSTART;
    end else begin
      res.status = fcp_pkg::ST_INCOMPLETE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fcp_pkg::PH_SEEK;
    end else begin
      phase_r <= phase_nxt;
    end
    status_r <= status_nxt;
    load_r   <= load_nxt;
    report_r <= report_nxt;
    kp_r     <= kp_nxt;
    ti_r     <= ti_nxt;
    td_r     <= td_nxt;
    cs_r     <= cs_nxt;
    sum_r    <= sum_nxt;
  end

endmodule

FILE: sv/framed_command_parser.sv
// Framed command parser: ring of byte cells, a frame scanner and the output register.
// Append, clear and unused mode: result in the cycle after the input transfer; one item
// per cycle while the result side keeps up. Decode: no input is taken while the ring
// rotates once past the scanner; the result is registered when the rotation is done.
// Reset clears the fill count, the gains and all control; buffer cells are not reset.
// Depends on fcp_pkg, fcp_cell, fcp_scanner.
module framed_command_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fcp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fcp_pkg::out_item_t  out_data
);

  fcp_pkg::ctl_state_t state_r, state_nxt;
  logic [fcp_pkg::IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [fcp_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0] gain_p_r, gain_p_nxt;
  logic [7:0] gain_i_r, gain_i_nxt;
  logic [7:0] gain_d_r, gain_d_nxt;
  logic       out_valid_r, out_valid_nxt;
  fcp_pkg::out_item_t out_data_r, out_data_nxt;

  logic in_fire;
  logic is_decode;
  logic append_ok;
  logic scan_step;
  logic scan_last;
  logic [7:0] cell_q [fcp_pkg::BUFFER_DEPTH];
  fcp_pkg::scan_ctl_t scan_ctl;
  fcp_pkg::scan_res_t scan_res;

  assign in_fire   = in_valid && in_ready;
  assign is_decode = in_data.mode == fcp_pkg::MODE_DECODE;
  assign append_ok = in_fire && in_data.mode == fcp_pkg::MODE_APPEND &&
                     fill_r < fcp_pkg::FILL_W'(fcp_pkg::BUFFER_DEPTH);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fcp_pkg::CS_IDLE: begin
        if (in_fire && is_decode) begin
          state_nxt = fcp_pkg::CS_SCAN;
        end
      end
      fcp_pkg::CS_SCAN: begin
        if (cnt_r == fcp_pkg::IDX_W'(fcp_pkg::BUFFER_DEPTH - 1)) begin
          state_nxt = fcp_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = fcp_pkg::CS_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    scan_step = 1'b0;
    scan_last = 1'b0;
    case (state_r)
      fcp_pkg::CS_IDLE: begin
        in_ready = !out_valid_r || out_ready;
      end
      fcp_pkg::CS_SCAN: begin
        scan_step = 1'b1;
        scan_last = cnt_r == fcp_pkg::IDX_W'(fcp_pkg::BUFFER_DEPTH - 1);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  genvar k;
  generate
    for (k = 0; k < fcp_pkg::BUFFER_DEPTH; k++) begin : g_cell
      fcp_pkg::cell_ctl_t cell_ctl;
      assign cell_ctl.load  = append_ok && fill_r == fcp_pkg::FILL_W'(k);
      assign cell_ctl.shift = scan_step;
      fcp_cell u_cell (
        .clk       (clk),
        .ctl       (cell_ctl),
        .load_byte (in_data.data_byte),
        .shift_in  (cell_q[(k + 1) % fcp_pkg::BUFFER_DEPTH]),
        .byte_q    (cell_q[k])
      );
    end
  endgenerate

  assign scan_ctl.start = in_fire && is_decode;
  assign scan_ctl.step  = scan_step;
  assign scan_ctl.empty = fill_r == '0;

  fcp_scanner u_scanner (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .head_byte (cell_q[0]),
    .in_range  ({1'b0, cnt_r} < fill_r),
    .res       (scan_res)
  );

  // datapath next values
  always_comb begin
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    gain_p_nxt    = gain_p_r;
    gain_i_nxt    = gain_i_r;
    gain_d_nxt    = gain_d_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (scan_ctl.start) begin
      cnt_nxt = '0;
    end else if (scan_step) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (in_fire && !is_decode) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.status         = fcp_pkg::ST_OK;
      out_data_nxt.gain_p         = gain_p_r;
      out_data_nxt.gain_i         = gain_i_r;
      out_data_nxt.gain_d         = gain_d_r;
      out_data_nxt.report_request = 1'b0;
      if (in_data.mode == fcp_pkg::MODE_APPEND) begin
        if (append_ok) begin
          fill_nxt = fill_r + 1'b1;
        end else begin
          out_data_nxt.status = fcp_pkg::ST_FULL;
        end
      end else if (in_data.mode == fcp_pkg::MODE_CLEAR) begin
        fill_nxt = '0;
      end
    end
    if (scan_last) begin
      if (scan_res.load) begin
        gain_p_nxt = scan_res.kp;
        gain_i_nxt = scan_res.ti;
        gain_d_nxt = scan_res.td;
      end
      if (scan_res.status == fcp_pkg::ST_OK) begin
        fill_nxt = '0;
      end
      out_valid_nxt               = 1'b1;
      out_data_nxt.status         = scan_res.status;
      out_data_nxt.gain_p         = gain_p_nxt;
      out_data_nxt.gain_i         = gain_i_nxt;
      out_data_nxt.gain_d         = gain_d_nxt;
      out_data_nxt.report_request = scan_res.report;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcp_pkg::CS_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      gain_p_r    <= gain_p_nxt;
      gain_i_r    <= gain_i_nxt;
      gain_d_r    <= gain_d_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sv/fcp_checker.sv
// Port-level checks of the framed command parser, bound to the top level.
// Depends on fcp_pkg and framed_command_parser_defines.svh.
`include "framed_command_parser_defines.svh"

module fcp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input fcp_pkg::in_item_t   in_data,
  input logic                out_valid,
  input logic                out_ready,
  input fcp_pkg::out_item_t  out_data
);

  `FCP_ASSERT_NOW(a_status_range, out_valid, out_data.status <= fcp_pkg::ST_FULL)
  `FCP_ASSERT_NOW(a_report_ok, out_valid && out_data.report_request, out_data.status == fcp_pkg::ST_OK)
  `FCP_ASSERT_NOW(a_slot_free, in_valid && in_ready, !out_valid || out_ready)
  `FCP_ASSERT_NEXT(a_quick_result, in_valid && in_ready && in_data.mode != fcp_pkg::MODE_DECODE, out_valid)
  `FCP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind framed_command_parser fcp_checker u_fcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: test/testbench.sv
// Self-checking testbench for framed_command_parser: directed frames, then random traffic.
// Predicts every reply in-line and checks it in order; depends on fcp_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_ITEMS = 1800;
  localparam int MAX_REPORTED = 10;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  fcp_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  fcp_pkg::out_item_t out_data;

  framed_command_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // Shadow of the parser state
  logic [7:0] held_bytes [fcp_pkg::BUFFER_DEPTH];
  int         held_count = 0;
  logic [7:0] kp_q = '0;
  logic [7:0] ti_q = '0;
  logic [7:0] td_q = '0;

  fcp_pkg::in_item_t  pending_cmds [$];
  fcp_pkg::out_item_t parser_replies [$];

  int unsigned cyc = 0;
  int unsigned sent_count = 0;
  int unsigned got_count = 0;
  int unsigned mismatches = 0;
  int unsigned gain_loads = 0;
  int unsigned report_hits = 0;
  int unsigned full_drops = 0;
  int unsigned decode_errs = 0;

  always @(posedge clk) cyc <= cyc + 1;

  function automatic logic [2:0] decode_held(output logic report);
    int s;
    logic [7:0] sum;
    report = 1'b0;
    if (held_count == 0) return fcp_pkg::ST_INCOMPLETE;
    s = 0;
    while (s < held_count && held_bytes[s] != fcp_pkg::SYM_START) s++;
    if (s >= held_count) return fcp_pkg::ST_NOSTART;
    if (s + 1 >= held_count) return fcp_pkg::ST_INCOMPLETE;
    if (held_bytes[s + 1] == fcp_pkg::CMD_P) begin
      if (s + 6 >= held_count) return fcp_pkg::ST_INCOMPLETE;
      if (held_bytes[s + 6] != fcp_pkg::SYM_END) return fcp_pkg::ST_FRAMING;
      sum = fcp_pkg::CMD_P + held_bytes[s + 2] + held_bytes[s + 3] + held_bytes[s + 4];
      if (sum != held_bytes[s + 5]) return fcp_pkg::ST_CHECKSUM;
      kp_q = held_bytes[s + 2];
      ti_q = held_bytes[s + 3];
      td_q = held_bytes[s + 4];
      held_count = 0;
      return fcp_pkg::ST_OK;
    end
    if (held_bytes[s + 1] == fcp_pkg::CMD_S) begin
      if (s + 2 >= held_count) return fcp_pkg::ST_INCOMPLETE;
      if (held_bytes[s + 2] != fcp_pkg::SYM_END) return fcp_pkg::ST_FRAMING;
      report = 1'b1;
      held_count = 0;
      return fcp_pkg::ST_OK;
    end
    return fcp_pkg::ST_INVALID;
  endfunction

  // Advance the shadow state by one command and queue the reply it yields
  function automatic void apply_command(fcp_pkg::in_item_t cmd);
    fcp_pkg::out_item_t rep;
    logic               rpt;
    rep = '0;
    rpt = 1'b0;
    rep.status = fcp_pkg::ST_OK;
    case (cmd.mode)
      fcp_pkg::MODE_APPEND: begin
        if (held_count < fcp_pkg::BUFFER_DEPTH) begin
          held_bytes[held_count] = cmd.data_byte;
          held_count++;
        end else begin
          rep.status = fcp_pkg::ST_FULL;
          full_drops++;
        end
      end
      fcp_pkg::MODE_DECODE: begin
        rep.status = decode_held(rpt);
        if (rep.status != fcp_pkg::ST_OK) decode_errs++;
        else if (rpt) report_hits++;
        else gain_loads++;
      end
      fcp_pkg::MODE_CLEAR: begin
        held_count = 0;
      end
      default: ;
    endcase
    rep.gain_p = kp_q;
    rep.gain_i = ti_q;
    rep.gain_d = td_q;
    rep.report_request = rpt;
    parser_replies.push_back(rep);
  endfunction

  function automatic void check_reply(fcp_pkg::out_item_t got);
    fcp_pkg::out_item_t want;
    if (parser_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTED)
        $display("%0t: reply with nothing outstanding: %p", $realtime, got);
      return;
    end
    want = parser_replies.pop_front();
    if (got.status !== want.status || got.gain_p !== want.gain_p ||
        got.gain_i !== want.gain_i || got.gain_d !== want.gain_d ||
        got.report_request !== want.report_request) begin
      mismatches++;
      if (mismatches <= MAX_REPORTED)
        $display("%0t: reply %0d mismatch: expected %p, got %p",
                 $realtime, got_count, want, got);
    end
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Driver
  int unsigned idle_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      idle_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        apply_command(in_data);
        sent_count++;
      end
      if (idle_left != 0) begin
        in_valid  <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_cmds.size() != 0) begin
        in_data   <= pending_cmds.pop_front();
        in_valid  <= 1'b1;
        idle_left <= (cyc[9:8] == 2'd0) ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        check_reply(out_data);
        got_count++;
      end
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if (cyc[10:9] != 2'd1 && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
    end
  end

  task automatic queue_item(input logic [1:0] m, input logic [7:0] b);
    fcp_pkg::in_item_t it;
    it.mode = m;
    it.data_byte = b;
    pending_cmds.push_back(it);
  endtask

  task automatic queue_ctl(input logic [1:0] m);
    queue_item(m, 8'($urandom_range(0, 255)));
  endtask

  // First n_bytes of "#P kp ti td cs end"
  task automatic queue_p_frame(input logic [7:0] kp, input logic [7:0] ti,
                               input logic [7:0] td, input logic [7:0] cs,
                               input logic [7:0] endb, input int n_bytes);
    logic [7:0] f [7];
    f[0] = fcp_pkg::SYM_START;
    f[1] = fcp_pkg::CMD_P;
    f[2] = kp;
    f[3] = ti;
    f[4] = td;
    f[5] = cs;
    f[6] = endb;
    for (int k = 0; k < n_bytes; k++) queue_item(fcp_pkg::MODE_APPEND, f[k]);
  endtask

  function automatic logic [7:0] pick_gain();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return 8'h00;
    if (r < 4) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_filler();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == fcp_pkg::SYM_START) b = b ^ 8'h01;
    return b;
  endfunction

  task automatic build_directed();
    queue_ctl(fcp_pkg::MODE_DECODE);                 // empty buffer
    queue_item(fcp_pkg::MODE_RESERVED, 8'hFF);       // unused mode
    queue_item(fcp_pkg::MODE_APPEND, 8'h00);
    queue_ctl(fcp_pkg::MODE_DECODE);                 // no start byte
    queue_item(fcp_pkg::MODE_APPEND, fcp_pkg::SYM_START);
    queue_ctl(fcp_pkg::MODE_DECODE);                 // start byte in last slot
    queue_p_frame(8'hFF, 8'h00, 8'h7F, 8'(fcp_pkg::CMD_P + 8'hFF + 8'h7F),
                  fcp_pkg::SYM_END, 7);
    queue_ctl(fcp_pkg::MODE_DECODE);                 // lone '#' followed by '#': bad command
    queue_item(fcp_pkg::MODE_APPEND, fcp_pkg::SYM_START);
    queue_item(fcp_pkg::MODE_APPEND, fcp_pkg::CMD_S);
    queue_item(fcp_pkg::MODE_APPEND, fcp_pkg::SYM_END);
    queue_ctl(fcp_pkg::MODE_DECODE);
    queue_item(fcp_pkg::MODE_APPEND, fcp_pkg::SYM_START);
    queue_item(fcp_pkg::MODE_APPEND, 8'h51);
    queue_item(fcp_pkg::MODE_APPEND, fcp_pkg::SYM_END);
    queue_ctl(fcp_pkg::MODE_DECODE);
    queue_ctl(fcp_pkg::MODE_CLEAR);
  endtask

  task automatic build_random();
    int unsigned kind;
    int unsigned n;
    logic [7:0] kp, ti, td, cs, endb;
    while (pending_cmds.size() < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 7) queue_ctl(fcp_pkg::MODE_CLEAR);
      n = $urandom_range(0, 3);
      repeat (n) queue_item(fcp_pkg::MODE_APPEND, pick_filler());
      kp = pick_gain();
      ti = pick_gain();
      td = pick_gain();
      cs = fcp_pkg::CMD_P + kp + ti + td;
      if (kind < 35) begin
        queue_p_frame(kp, ti, td, cs, fcp_pkg::SYM_END, 7);
        if ($urandom_range(0, 3) == 0)
          queue_item(fcp_pkg::MODE_APPEND, 8'($urandom_range(0, 255)));
        queue_ctl(fcp_pkg::MODE_DECODE);
      end else if (kind < 50) begin
        queue_item(fcp_pkg::MODE_APPEND, fcp_pkg::SYM_START);
        queue_item(fcp_pkg::MODE_APPEND, fcp_pkg::CMD_S);
        queue_item(fcp_pkg::MODE_APPEND, fcp_pkg::SYM_END);
        queue_ctl(fcp_pkg::MODE_DECODE);
      end else if (kind < 60) begin
        // checksum off by a nonzero amount
        queue_p_frame(kp, ti, td, 8'(cs + $urandom_range(1, 255)), fcp_pkg::SYM_END, 7);
        queue_ctl(fcp_pkg::MODE_DECODE);
      end else if (kind < 68) begin
        endb = 8'($urandom_range(0, 255));
        if (endb == fcp_pkg::SYM_END) endb = endb ^ 8'h01;
        if ($urandom_range(0, 1) == 0) begin
          queue_p_frame(kp, ti, td, cs, endb, 7);
        end else begin
          queue_item(fcp_pkg::MODE_APPEND, fcp_pkg::SYM_START);
          queue_item(fcp_pkg::MODE_APPEND, fcp_pkg::CMD_S);
          queue_item(fcp_pkg::MODE_APPEND, endb);
        end
        queue_ctl(fcp_pkg::MODE_DECODE);
      end else if (kind < 76) begin
        // cut-short frame, sometimes followed by an S frame and decoded again
        n = $urandom_range(1, 6);
        queue_p_frame(kp, ti, td, cs, fcp_pkg::SYM_END, n);
        queue_ctl(fcp_pkg::MODE_DECODE);
        if ($urandom_range(0, 1) == 0) begin
          queue_item(fcp_pkg::MODE_APPEND, fcp_pkg::SYM_START);
          queue_item(fcp_pkg::MODE_APPEND, fcp_pkg::CMD_S);
          queue_ctl(fcp_pkg::MODE_DECODE);
          queue_item(fcp_pkg::MODE_APPEND, fcp_pkg::SYM_END);
          queue_ctl(fcp_pkg::MODE_DECODE);
        end
      end else if (kind < 82) begin
        kp = 8'($urandom_range(0, 255));
        if (kp == fcp_pkg::CMD_P || kp == fcp_pkg::CMD_S) kp = kp ^ 8'h01;
        queue_item(fcp_pkg::MODE_APPEND, fcp_pkg::SYM_START);
        queue_item(fcp_pkg::MODE_APPEND, kp);
        repeat ($urandom_range(0, 5))
          queue_item(fcp_pkg::MODE_APPEND, 8'($urandom_range(0, 255)));
        queue_ctl(fcp_pkg::MODE_DECODE);
      end else if (kind < 88) begin
        repeat ($urandom_range(14, 20))
          queue_item(fcp_pkg::MODE_APPEND, 8'($urandom_range(0, 255)));
        queue_ctl(fcp_pkg::MODE_DECODE);
      end else begin
        repeat ($urandom_range(1, 8))
          queue_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    build_directed();
    build_random();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_cmds.size() != 0 || in_valid || parser_replies.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d commands, checked %0d replies: %0d gain loads, %0d status reports,",
             sent_count, got_count, gain_loads, report_hits);
    $display("%0d dropped bytes on a full buffer, %0d decode errors, %0d mismatches.",
             full_drops, decode_errs, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Timeout: %0d commands sent, %0d replies checked", sent_count, got_count);
    $display("TEST FAILED");
    $finish;
  end

endmodule
